// ===== rtl/cna_pkg.sv =====
// Shared types and constants for the complex number ALU.
package cna_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

endpackage

// ===== rtl/cna_div_step.sv =====
// One registered restoring-division step: one quotient bit per stage.
module cna_div_step import cna_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [3*WORD_WIDTH+FRAC_BITS+1:0] rem_in,
  input  logic [WORD_WIDTH+1:0]          q_in,
  input  logic [2*WORD_WIDTH-1:0]        den_in,
  output logic [3*WORD_WIDTH+FRAC_BITS+1:0] rem,
  output logic [WORD_WIDTH+1:0]          q
);

  localparam int CW = 3 * WORD_WIDTH + FRAC_BITS + 2;
  localparam int QW = WORD_WIDTH + 2;

  logic [CW-1:0] sub;
  logic          ge;

  assign sub = CW'(den_in) << SHIFT;
  assign ge  = rem_in >= sub;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem <= ge ? rem_in - sub : rem_in;
      q   <= {q_in[QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/complex_number_alu.sv =====
// Top level of the pipelined complex number ALU (add, subtract, multiply, divide).
//
//   channel | signals                                     | flow control
//   in      | opcode, a_real, a_imag, b_real, b_imag       | in_valid / in_stall
//   out     | result_real, result_imag, status             | out_valid / out_stall
//
// One request enters per cycle while in_stall is low; every opcode passes through the
// same stages, ending in the quotient pipeline, one bit per stage over WORD_WIDTH + 2 stages.
// Reset clears the valid bits only; payload registers are not reset.
// A stalled result holds the whole pipeline; in_stall rises only while out_stall
// holds a valid result, so nothing is dropped or repeated.
module complex_number_alu import cna_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_real,
  output logic signed [31:0] result_imag,
  output logic [1:0]         status
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NS = W + 2;
  localparam int CW = 3 * W + F + 2;
  localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [NS-1:0] LIM  = NS'(1) << (W - 1);

  function automatic logic [W:0] sat_word(input logic signed [SW-1:0] v);
    logic [SW-W:0] top;
    top = v[SW-1:W-1];
    if (top == '0 || top == '1) return {1'b0, v[W-1:0]};
    return {1'b1, v[SW-1] ? MINW : MAXW};
  endfunction

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic                  s1_valid;
  opcode_t               s1_op;
  logic signed [W-1:0]   s1_a, s1_b, s1_c, s1_d;
  logic signed [W:0]     s1_as_re, s1_as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= opcode_t'(opcode);
      s1_a  <= a_real[W-1:0];
      s1_b  <= a_imag[W-1:0];
      s1_c  <= b_real[W-1:0];
      s1_d  <= b_imag[W-1:0];
    end
  end

  always_comb begin
    if (s1_op == OP_SUB) begin
      s1_as_re = (W+1)'(s1_a) - (W+1)'(s1_c);
      s1_as_im = (W+1)'(s1_b) - (W+1)'(s1_d);
    end else begin
      s1_as_re = (W+1)'(s1_a) + (W+1)'(s1_c);
      s1_as_im = (W+1)'(s1_b) + (W+1)'(s1_d);
    end
  end

  logic                 s2_valid;
  opcode_t              s2_op;
  logic signed [PW-1:0] s2_ac, s2_bd, s2_ad, s2_bc, s2_cc, s2_dd;
  logic signed [W:0]    s2_as_re, s2_as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op    <= s1_op;
      s2_ac    <= PW'(s1_a) * PW'(s1_c);
      s2_bd    <= PW'(s1_b) * PW'(s1_d);
      s2_ad    <= PW'(s1_a) * PW'(s1_d);
      s2_bc    <= PW'(s1_b) * PW'(s1_c);
      s2_cc    <= PW'(s1_c) * PW'(s1_c);
      s2_dd    <= PW'(s1_d) * PW'(s1_d);
      s2_as_re <= s1_as_re;
      s2_as_im <= s1_as_im;
    end
  end

  logic                 s3_valid;
  opcode_t              s3_op;
  logic signed [SW-1:0] s3_mre, s3_mim, s3_nre, s3_nim;
  logic [PW-1:0]        s3_den;
  logic signed [W:0]    s3_as_re, s3_as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op    <= s2_op;
      s3_mre   <= SW'(s2_ac) - SW'(s2_bd);
      s3_mim   <= SW'(s2_ad) + SW'(s2_bc);
      s3_nre   <= SW'(s2_ac) + SW'(s2_bd);
      s3_nim   <= SW'(s2_bc) - SW'(s2_ad);
      s3_den   <= $unsigned(s2_cc) + $unsigned(s2_dd);
      s3_as_re <= s2_as_re;
      s3_as_im <= s2_as_im;
    end
  end

  logic signed [SW-1:0] s3_v_re, s3_v_im;
  logic [W:0]           s3_w_re, s3_w_im;
  logic [SW-1:0]        s3_mag_re, s3_mag_im;

  always_comb begin
    case (s3_op)
      OP_MUL: begin
        s3_v_re = s3_mre >>> F;
        s3_v_im = s3_mim >>> F;
      end
      default: begin
        s3_v_re = SW'(s3_as_re);
        s3_v_im = SW'(s3_as_im);
      end
    endcase
    s3_w_re   = sat_word(s3_v_re);
    s3_w_im   = sat_word(s3_v_im);
    s3_mag_re = s3_nre[SW-1] ? $unsigned(-s3_nre) : $unsigned(s3_nre);
    s3_mag_im = s3_nim[SW-1] ? $unsigned(-s3_nim) : $unsigned(s3_nim);
  end

  logic          p_valid  [NS+1];
  logic          p_div    [NS+1];
  logic          p_dz     [NS+1];
  logic          p_neg_re [NS+1];
  logic          p_neg_im [NS+1];
  logic          p_sat    [NS+1];
  logic [W-1:0]  p_res_re [NS+1];
  logic [W-1:0]  p_res_im [NS+1];
  logic [PW-1:0] p_den    [NS+1];
  logic [CW-1:0] p_rem_re [NS+1];
  logic [CW-1:0] p_rem_im [NS+1];
  logic [NS-1:0] p_q_re   [NS+1];
  logic [NS-1:0] p_q_im   [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid[0] <= 1'b0;
    end else if (adv) begin
      p_valid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_div[0]    <= s3_op == OP_DIV;
      p_dz[0]     <= s3_den == '0;
      p_neg_re[0] <= s3_nre[SW-1];
      p_neg_im[0] <= s3_nim[SW-1];
      p_sat[0]    <= s3_w_re[W] || s3_w_im[W];
      p_res_re[0] <= s3_w_re[W-1:0];
      p_res_im[0] <= s3_w_im[W-1:0];
      p_den[0]    <= s3_den;
      p_rem_re[0] <= CW'(s3_mag_re) << F;
      p_rem_im[0] <= CW'(s3_mag_im) << F;
      p_q_re[0]   <= '0;
      p_q_im[0]   <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    cna_div_step #(.WORD_WIDTH(W), .FRAC_BITS(F), .SHIFT(NS - 1 - k)) u_re (
      .clk(clk), .adv(adv), .rem_in(p_rem_re[k]), .q_in(p_q_re[k]),
      .den_in(p_den[k]), .rem(p_rem_re[k+1]), .q(p_q_re[k+1])
    );
    cna_div_step #(.WORD_WIDTH(W), .FRAC_BITS(F), .SHIFT(NS - 1 - k)) u_im (
      .clk(clk), .adv(adv), .rem_in(p_rem_im[k]), .q_in(p_q_im[k]),
      .den_in(p_den[k]), .rem(p_rem_im[k+1]), .q(p_q_im[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        p_valid[k+1] <= 1'b0;
      end else if (adv) begin
        p_valid[k+1] <= p_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p_div[k+1]    <= p_div[k];
        p_dz[k+1]     <= p_dz[k];
        p_neg_re[k+1] <= p_neg_re[k];
        p_neg_im[k+1] <= p_neg_im[k];
        p_sat[k+1]    <= p_sat[k];
        p_res_re[k+1] <= p_res_re[k];
        p_res_im[k+1] <= p_res_im[k];
        p_den[k+1]    <= p_den[k];
      end
    end
  end

  logic          f_neg_re, f_neg_im, f_sat_re, f_sat_im;
  logic [NS-1:0] f_q_re, f_q_im;
  logic [W-1:0]  f_re, f_im;
  status_t       f_status;

  always_comb begin
    f_q_re   = p_q_re[NS];
    f_q_im   = p_q_im[NS];
    f_neg_re = p_neg_re[NS] && f_q_re != '0;
    f_neg_im = p_neg_im[NS] && f_q_im != '0;
    f_sat_re = f_neg_re ? f_q_re > LIM : f_q_re > LIM - NS'(1);
    f_sat_im = f_neg_im ? f_q_im > LIM : f_q_im > LIM - NS'(1);
    if (!p_div[NS]) begin
      f_re     = p_res_re[NS];
      f_im     = p_res_im[NS];
      f_status = p_sat[NS] ? ST_SAT : ST_OK;
    end else if (p_dz[NS]) begin
      f_re     = '0;
      f_im     = '0;
      f_status = ST_DIV0;
    end else begin
      if (f_sat_re) f_re = f_neg_re ? MINW : MAXW;
      else          f_re = f_neg_re ? -f_q_re[W-1:0] : f_q_re[W-1:0];
      if (f_sat_im) f_im = f_neg_im ? MINW : MAXW;
      else          f_im = f_neg_im ? -f_q_im[W-1:0] : f_q_im[W-1:0];
      f_status = (f_sat_re || f_sat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_real <= 32'($signed(f_re));
      result_imag <= 32'($signed(f_im));
      status      <= f_status;
    end
  end

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIV0 |-> result_real == '0 && result_imag == '0)
    else $error("divide by zero request returned nonzero parts");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted request lost at pipeline entry");

endmodule
